// File: rtl/core/sldf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_pkg
// Shared constants and types of the sync/length frame deframer.
// ----------------------------------------------------------------------------
package sldf_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 512;

   localparam int BYTE_W    = 8;
   localparam int OFFSET_W  = 9;
   localparam int FLEN_W    = 10;
   localparam int PAYLEN_W  = 16;

   localparam int LEN_LOW_POS  = 7;
   localparam int LEN_HIGH_POS = 8;
   localparam int HEADER_BYTES = 9;

   // tdata of a response: data_byte, byte_offset, frame_length, zero fill
   localparam int RSP_DATA_W = 32;
   // tuser of a response: stored, overflow_drop
   localparam int RSP_USER_W = 2;

   typedef struct packed {
      logic                stored;
      logic [BYTE_W-1:0]   data_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic                frame_done;
      logic [FLEN_W-1:0]   frame_length;
      logic                overflow_drop;
   } result_type;

endpackage

// File: rtl/core/sldf_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_step
// Frame tracking for one byte: drop check, sync hunt, header and payload count.
// ----------------------------------------------------------------------------
module sldf_step import sldf_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
   parameter int FILL_W       = $clog2(BUFFER_BYTES + 1)
) (
   input  logic [BYTE_W-1:0]   rx_byte,
   input  logic [BYTE_W-1:0]   sync_byte,
   input  logic [FILL_W-1:0]   fill_cur,
   input  logic [PAYLEN_W-1:0] remain_cur,
   output logic [FILL_W-1:0]   fill_next,
   output logic [PAYLEN_W-1:0] remain_next,
   output result_type          result
);

   logic                drop;
   logic [FILL_W-1:0]   fill_a;
   logic [PAYLEN_W-1:0] remain_a;
   logic [FILL_W-1:0]   fill_b;
   logic [PAYLEN_W-1:0] remain_b;
   logic                stored;
   logic [FILL_W-1:0]   offset;
   logic                done;

   always_comb begin
      drop     = (fill_cur >= FILL_W'(BUFFER_BYTES));
      // abandon the partial frame and look at this byte from the hunt state
      fill_a   = drop ? '0 : fill_cur;
      remain_a = drop ? '0 : remain_cur;
      fill_b   = fill_a;
      remain_b = remain_a;
      stored   = 1'b0;
      offset   = '0;
      priority if (fill_a == '0) begin
         if (rx_byte == sync_byte) begin
            stored = 1'b1;
            fill_b = FILL_W'(1);
         end
      end else if (fill_a < FILL_W'(HEADER_BYTES)) begin
         if (fill_a == FILL_W'(LEN_LOW_POS)) begin
            remain_b = PAYLEN_W'(rx_byte);
         end else if (fill_a == FILL_W'(LEN_HIGH_POS)) begin
            remain_b = {rx_byte, remain_a[BYTE_W-1:0]};
         end
         stored = 1'b1;
         offset = fill_a;
         fill_b = fill_a + FILL_W'(1);
      end else if (remain_a != '0) begin
         stored   = 1'b1;
         offset   = fill_a;
         fill_b   = fill_a + FILL_W'(1);
         remain_b = remain_a - PAYLEN_W'(1);
      end

      done        = (fill_b >= FILL_W'(HEADER_BYTES)) && (remain_b == '0);
      fill_next   = done ? '0 : fill_b;
      remain_next = remain_b;

      result.stored        = stored;
      result.data_byte     = stored ? rx_byte : '0;
      result.byte_offset   = OFFSET_W'(offset);
      result.frame_done    = done;
      result.frame_length  = done ? FLEN_W'(fill_b) : '0;
      result.overflow_drop = drop;
   end

endmodule

// File: rtl/core/sldf_rsp_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_rsp_reg
// Response register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sldf_rsp_reg import sldf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            result,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // data_byte, byte_offset, frame_length
   output logic [RSP_USER_W-1:0] rsp_tuser,   // stored, overflow_drop
   output logic                  rsp_tlast    // frame_done
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({result_ff.frame_length, result_ff.byte_offset,
                                    result_ff.data_byte});
   assign rsp_tuser  = {result_ff.overflow_drop, result_ff.stored};
   assign rsp_tlast  = result_ff.frame_done;

endmodule

// File: rtl/core/sync_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_unit
// Sync-byte hunt and length-prefixed frame assembly, one response per byte.
// ----------------------------------------------------------------------------
// The unit takes one received byte per clock unless downstream backpressure
// holds it, and returns one response per byte through the request register
// and then the response register. The frame counters update in the same
// cycle as a byte moves from the request register to the response register,
// so the rate is one byte per clock, limited only by backpressure. A frame
// is the sync byte, eight more header bytes, and the payload whose length is
// header bytes 7 and 8 (little-endian). rsp_tlast marks the byte that closes a
// frame; a frame that grows past BUFFER_BYTES is dropped and flagged in
// rsp_tuser. Write csr_wr_data (the sync byte) only while the unit is idle.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_unit import sldf_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [BYTE_W-1:0]     csr_wr_data,  // sync_byte
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,    // rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // data_byte, byte_offset, frame_length
   output logic [RSP_USER_W-1:0] rsp_tuser,    // stored, overflow_drop
   output logic                  rsp_tlast     // frame_done
);

   localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

   logic [BYTE_W-1:0]   sync_ff;
   logic                req_valid_ff;
   logic                req_valid_in;
   logic [BYTE_W-1:0]   req_byte_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic [PAYLEN_W-1:0] remain_ff;
   logic [PAYLEN_W-1:0] remain_in;
   logic                rsp_free;
   logic                advance;
   result_type          step_result;

   assign advance      = req_valid_ff && rsp_free;
   assign req_tready   = !req_valid_ff || advance;
   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= '0;
         req_valid_ff <= 1'b0;
         fill_ff      <= '0;
         remain_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
         req_valid_ff <= req_valid_in;
         // advance the frame counters only when the request moves on
         if (advance) begin
            fill_ff   <= fill_in;
            remain_ff <= remain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_byte_ff <= req_tdata;
      end
   end

   sldf_step #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .FILL_W       (FILL_W)
   ) u_step (
      .rx_byte     (req_byte_ff),
      .sync_byte   (sync_ff),
      .fill_cur    (fill_ff),
      .remain_cur  (remain_ff),
      .fill_next   (fill_in),
      .remain_next (remain_in),
      .result      (step_result)
   );

   sldf_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (step_result),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // the fill count never passes the buffer size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BUFFER_BYTES))
      else $error("fill count beyond buffer size");

   // payload left to collect only once the low length byte is in
   a_remain_header: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) |-> (fill_ff > FILL_W'(LEN_LOW_POS)))
      else $error("payload count outside a frame");

   // a frame closes only on a byte that was stored
   a_done_stored: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("frame end on a discarded byte");

   // counters hold while no request moves on
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(fill_ff) && $stable(remain_ff)))
      else $error("frame counters changed without a request");

endmodule
